### rtl/ring_record_allocator_evicting_macros.svh
// Assertion macros for the ring record allocator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef RING_RECORD_ALLOCATOR_EVICTING_MACROS_SVH
`define RING_RECORD_ALLOCATOR_EVICTING_MACROS_SVH

// Same-cycle implication, masked during reset.
`define RRAE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define RRAE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rrae_pkg.sv
// Shared types and constants for the ring record allocator.
// No dependencies; imported by every module of the block but rrae_ram.
package rrae_pkg;

    localparam int OFS_W            = 15;
    localparam int TAG_W            = 8;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int CNT_OUT_W        = 7;
    localparam int DEF_BUFFER_BYTES = 16384;
    localparam int DEF_MAX_RECORDS  = 64;

    localparam logic [OFS_W-1:0] CAP_RESET = 15'd10240;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_WALK,
        S_APPEND,
        S_POP_RD,
        S_POP_FIN,
        S_MISC,
        S_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic push_chk;
        logic walk;
        logic append;
        logic pop_rd;
        logic pop_empty;
        logic pop_fin;
        logic misc;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t in_mode;
        logic  oversize;
        logic  need_evict;
        logic  count_zero;
        logic  walk_stop;
        logic  out_free;
    } sts_t;

endpackage

### rtl/rrae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/rrae_ctrl.sv
// Sequencer for the ring record allocator: one word at a time.
// Depends on rrae_pkg (state, command and status types).
module rrae_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rrae_pkg::sts_t sts,
    output rrae_pkg::cmd_t cmd
);
    import rrae_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (sts.in_mode)
                        MODE_PUSH:  state_next = S_PUSH_CHK;
                        MODE_POP:   state_next = S_POP_RD;
                        MODE_CLEAR: state_next = S_MISC;
                        MODE_NOP:   state_next = S_MISC;
                    endcase
                end
            end
            S_PUSH_CHK:
            begin
                cmd.push_chk = 1'b1;
                priority if (sts.oversize)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.need_evict && !sts.count_zero)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_stop)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_EMIT;
            end
            S_POP_RD:
            begin
                if (sts.count_zero)
                begin
                    cmd.pop_empty = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_FIN;
                end
            end
            S_POP_FIN:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = S_EMIT;
            end
            S_MISC:
            begin
                cmd.misc   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/rrae_dp.sv
// Datapath of the ring record allocator: offsets, list pointers,
// record table RAM, result and output registers.
// Depends on rrae_pkg, rrae_ram and the assertion macro header.
`include "ring_record_allocator_evicting_macros.svh"

module rrae_dp #(
    parameter int BUFFER_BYTES = rrae_pkg::DEF_BUFFER_BYTES,
    parameter int MAX_RECORDS  = rrae_pkg::DEF_MAX_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [rrae_pkg::OFS_W-1:0]      capacity_bytes,
    input  logic [rrae_pkg::MODE_W-1:0]     mode,
    input  logic [rrae_pkg::OFS_W-1:0]      record_size,
    input  logic [rrae_pkg::TAG_W-1:0]      record_tag,
    input  rrae_pkg::cmd_t                  cmd,
    output rrae_pkg::sts_t                  sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rrae_pkg::STATUS_W-1:0]   status,
    output logic [rrae_pkg::OFS_W-1:0]      record_offset,
    output logic [rrae_pkg::OFS_W-1:0]      record_length,
    output logic [rrae_pkg::TAG_W-1:0]      record_kind,
    output logic [rrae_pkg::CNT_OUT_W-1:0]  evicted_count,
    output logic [rrae_pkg::CNT_OUT_W-1:0]  records_held
);
    import rrae_pkg::*;

    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int SW = IW + 1;
    localparam int RW = 2 * OFS_W + TAG_W;

    // (base + k) mod MAX_RECORDS; sum stays below twice the depth
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= SW'(MAX_RECORDS))
        begin
            s = s - SW'(MAX_RECORDS);
        end
        return s[IW-1:0];
    endfunction

    // control state
    logic [OFS_W-1:0] cap_reg;
    logic [OFS_W-1:0] head_reg,   head_next;
    logic [OFS_W-1:0] tail_reg,   tail_next;
    logic [IW-1:0]    oldest_reg, oldest_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    walk_reg,   walk_next;
    logic [CW-1:0]    evict_reg,  evict_next;
    mode_t            mode_reg,   mode_next;
    logic             out_valid_reg;

    // payload
    logic [OFS_W:0]   hs_reg,     hs_next;
    logic [OFS_W-1:0] size_reg,   size_next;
    logic [TAG_W-1:0] tag_reg,    tag_next;
    status_t          res_status_reg, res_status_next;
    logic [OFS_W-1:0] res_ofs_reg,    res_ofs_next;
    logic [OFS_W-1:0] res_len_reg,    res_len_next;
    logic [TAG_W-1:0] res_kind_reg,   res_kind_next;
    logic [CW-1:0]    res_ev_reg,     res_ev_next;
    logic [CW-1:0]    res_held_reg,   res_held_next;
    status_t          out_status_reg;
    logic [OFS_W-1:0] out_ofs_reg;
    logic [OFS_W-1:0] out_len_reg;
    logic [TAG_W-1:0] out_kind_reg;
    logic [CNT_OUT_W-1:0] out_ev_reg;
    logic [CNT_OUT_W-1:0] out_held_reg;

    // RAM
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [RW-1:0] wr_data;
    logic [RW-1:0] rd_data;
    logic [OFS_W-1:0] rd_start;
    logic [OFS_W-1:0] rd_size;
    logic [TAG_W-1:0] rd_tag;

    // combinational terms
    logic [OFS_W-1:0] cap;
    logic [OFS_W:0]   hs_now;
    logic             room_now;
    logic [OFS_W-1:0] head_wrap;
    logic [OFS_W:0]   walk_sum;
    logic [OFS_W-1:0] walk_end;
    logic             walk_room;
    logic             walk_last;
    logic             walk_stop;
    logic             oversize;
    logic             need_evict;
    logic [CW-1:0]    walk_inc;
    logic [CW-1:0]    count_inc;
    logic [CW-1:0]    count_left;

    assign cap = (32'(cap_reg) < BUFFER_BYTES) ? cap_reg : OFS_W'(BUFFER_BYTES);

    assign rd_start = rd_data[RW-1 -: OFS_W];
    assign rd_size  = rd_data[TAG_W +: OFS_W];
    assign rd_tag   = rd_data[TAG_W-1:0];

    // room test against the current head and tail
    assign hs_now   = {1'b0, head_reg} + {1'b0, size_reg};
    assign room_now = (head_reg >= tail_reg) ? (hs_now <= {1'b0, cap})
                                             : (hs_now <= {1'b0, tail_reg});
    assign oversize   = size_reg > cap;
    assign need_evict = (count_reg >= CW'(MAX_RECORDS)) || !room_now;
    assign head_wrap  = (need_evict && (head_reg > tail_reg)) ? '0 : head_reg;

    // eviction walk: tail moves to the end of the record just read
    assign walk_sum  = {1'b0, rd_start} + {1'b0, rd_size};
    assign walk_end  = walk_sum[OFS_W-1:0];
    assign walk_room = (head_reg >= walk_end) ? (hs_reg <= {1'b0, cap})
                                              : (hs_reg <= {1'b0, walk_end});
    assign walk_inc  = CW'(walk_reg + 1'b1);
    assign walk_last = walk_inc == count_reg;
    assign walk_stop = walk_room || walk_last;

    // list length after an append and after the walk stops
    assign count_inc  = CW'(count_reg + 1'b1);
    assign count_left = CW'(count_reg - walk_inc);

    always_comb
    begin
        priority if (cmd.walk)
        begin
            rd_addr = slot_of(oldest_reg, walk_inc);
        end
        else if (cmd.pop_rd)
        begin
            rd_addr = slot_of(oldest_reg, CW'(count_reg - 1'b1));
        end
        else
        begin
            rd_addr = oldest_reg;
        end
    end

    assign wr_addr = slot_of(oldest_reg, count_reg);
    assign wr_data = {head_reg, size_reg, tag_reg};

    rrae_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RECORDS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        evict_next      = evict_reg;
        mode_next       = mode_reg;
        hs_next         = hs_reg;
        size_next       = size_reg;
        tag_next        = tag_reg;
        res_status_next = res_status_reg;
        res_ofs_next    = res_ofs_reg;
        res_len_next    = res_len_reg;
        res_kind_next   = res_kind_reg;
        res_ev_next     = res_ev_reg;
        res_held_next   = res_held_reg;

        if (cmd.latch)
        begin
            size_next = record_size;
            tag_next  = record_tag;
            mode_next = mode_t'(mode);
        end

        if (cmd.push_chk)
        begin
            evict_next = '0;
            walk_next  = '0;
            // oversize result; overwritten by append otherwise
            res_status_next = ST_OVERSIZE;
            res_ofs_next    = head_reg;
            res_len_next    = size_reg;
            res_kind_next   = tag_reg;
            res_ev_next     = '0;
            res_held_next   = count_reg;
            if (!oversize)
            begin
                head_next = head_wrap;
                hs_next   = {1'b0, head_wrap} + {1'b0, size_reg};
            end
        end

        if (cmd.walk)
        begin
            tail_next = walk_end;
            walk_next = walk_inc;
            if (walk_stop)
            begin
                oldest_next = slot_of(oldest_reg, walk_inc);
                count_next  = CW'(count_reg - walk_inc);
                evict_next  = walk_inc;
            end
        end

        if (cmd.append)
        begin
            count_next      = CW'(count_reg + 1'b1);
            head_next       = hs_reg[OFS_W-1:0];
            res_status_next = ST_OK;
            res_ofs_next    = head_reg;
            res_len_next    = size_reg;
            res_kind_next   = tag_reg;
            res_ev_next     = evict_reg;
            res_held_next   = CW'(count_reg + 1'b1);
        end

        if (cmd.pop_empty)
        begin
            res_status_next = ST_EMPTY;
            res_ofs_next    = '0;
            res_len_next    = '0;
            res_kind_next   = '0;
            res_ev_next     = '0;
            res_held_next   = '0;
        end

        if (cmd.pop_fin)
        begin
            count_next      = CW'(count_reg - 1'b1);
            head_next       = rd_start;
            res_status_next = ST_OK;
            res_ofs_next    = rd_start;
            res_len_next    = rd_size;
            res_kind_next   = rd_tag;
            res_ev_next     = '0;
            res_held_next   = CW'(count_reg - 1'b1);
        end

        if (cmd.misc)
        begin
            res_status_next = ST_OK;
            res_ofs_next    = '0;
            res_len_next    = '0;
            res_kind_next   = '0;
            res_ev_next     = '0;
            res_held_next   = count_reg;
            if (mode_reg == MODE_CLEAR)
            begin
                head_next     = '0;
                tail_next     = '0;
                oldest_next   = '0;
                count_next    = '0;
                res_held_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            evict_reg     <= '0;
            mode_reg      <= MODE_NOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= capacity_bytes;
            end
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            evict_reg  <= evict_next;
            mode_reg   <= mode_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hs_reg         <= hs_next;
        size_reg       <= size_next;
        tag_reg        <= tag_next;
        res_status_reg <= res_status_next;
        res_ofs_reg    <= res_ofs_next;
        res_len_reg    <= res_len_next;
        res_kind_reg   <= res_kind_next;
        res_ev_reg     <= res_ev_next;
        res_held_reg   <= res_held_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_ofs_reg    <= res_ofs_reg;
            out_len_reg    <= res_len_reg;
            out_kind_reg   <= res_kind_reg;
            out_ev_reg     <= CNT_OUT_W'(res_ev_reg);
            out_held_reg   <= CNT_OUT_W'(res_held_reg);
        end
    end

    assign sts.in_mode    = mode_t'(mode);
    assign sts.oversize   = oversize;
    assign sts.need_evict = need_evict;
    assign sts.count_zero = count_reg == '0;
    assign sts.walk_stop  = walk_stop;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign record_offset = out_ofs_reg;
    assign record_length = out_len_reg;
    assign record_kind   = out_kind_reg;
    assign evicted_count = out_ev_reg;
    assign records_held  = out_held_reg;

    `RRAE_ASSERT_IMP(a_walk_in_range, cmd.walk, walk_reg < count_reg, "walk past list end")
    `RRAE_ASSERT_NXT(a_evict_count, cmd.walk && walk_stop, count_reg == $past(count_left), "evict")
    `RRAE_ASSERT_NXT(a_append_grows, cmd.append, count_reg == $past(count_inc), "append count")
    `RRAE_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CW'(MAX_RECORDS), "count over max")
    `RRAE_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid_reg || out_ready, "output busy")

endmodule

### rtl/ring_record_allocator_evicting.sv
// Top level of the ring record allocator with oldest-record eviction.
// Depends on rrae_pkg, rrae_ctrl and rrae_dp (which holds rrae_ram).

// Allocates byte space for variable-size records in a ring of
// min(capacity_bytes, BUFFER_BYTES) bytes and keeps up to MAX_RECORDS
// records in a list from oldest to newest. Each input word is one
// command (push, pop newest, clear, no-op) and yields exactly one result
// word. Words are processed one at a time. A push runs a check step,
// then the eviction walk if the list is not empty and is full or lacks
// room, then an append step; the walk reads oldest records until there
// is room or none is left, one record table entry per cycle from the
// table RAM, pipelined behind its registered read port. An oversize
// push skips the walk and append; a pop reads the newest entry, then
// finishes, or reports empty on an empty list; clear and no-op pass
// through the misc step. A finished result sits in the output register
// while the next word is accepted; the block only holds back when a
// second result is ready before the first is taken. The capacity_bytes
// register (reset 10240) is written through its own channel, always
// ready, and must only change while the block is idle. Record table
// entries carry no reset; only entries a push wrote are ever read.
module ring_record_allocator_evicting #(
    parameter int BUFFER_BYTES = rrae_pkg::DEF_BUFFER_BYTES,
    parameter int MAX_RECORDS  = rrae_pkg::DEF_MAX_RECORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrae_pkg::OFS_W-1:0]      capacity_bytes,
    // command channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rrae_pkg::MODE_W-1:0]     mode,
    input  logic [rrae_pkg::OFS_W-1:0]      record_size,
    input  logic [rrae_pkg::TAG_W-1:0]      record_tag,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rrae_pkg::STATUS_W-1:0]   status,
    output logic [rrae_pkg::OFS_W-1:0]      record_offset,
    output logic [rrae_pkg::OFS_W-1:0]      record_length,
    output logic [rrae_pkg::TAG_W-1:0]      record_kind,
    output logic [rrae_pkg::CNT_OUT_W-1:0]  evicted_count,
    output logic [rrae_pkg::CNT_OUT_W-1:0]  records_held
);
    import rrae_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // the capacity register takes every write; no back-pressure needed
    assign cfg_ready = 1'b1;

    // sequencer: decodes the command word, runs the eviction walk
    rrae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // head/tail offsets, list pointers, record table and result registers
    rrae_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_RECORDS  (MAX_RECORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .capacity_bytes (capacity_bytes),
        .mode           (mode),
        .record_size    (record_size),
        .record_tag     (record_tag),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .record_offset  (record_offset),
        .record_length  (record_length),
        .record_kind    (record_kind),
        .evicted_count  (evicted_count),
        .records_held   (records_held)
    );

endmodule

### dv/tb_ring_record_allocator_evicting.sv
// Self-checking testbench for ring_record_allocator_evicting.
// Depends on rrae_pkg and the RTL of the block; runs on its own with no inputs.
// Directed and random command words are checked against an in-bench ring predictor.
module tb_ring_record_allocator_evicting;
    import rrae_pkg::*;

    localparam int MAX_RECS  = DEF_MAX_RECORDS;
    localparam int BUF_BYTES = DEF_BUFFER_BYTES;
    localparam int SIZE_MAX  = (1 << OFS_W) - 1;

    // One result word as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0]  st;
        logic [OFS_W-1:0]     offset;
        logic [OFS_W-1:0]     length;
        logic [TAG_W-1:0]     kind;
        logic [CNT_OUT_W-1:0] evicted;
        logic [CNT_OUT_W-1:0] held;
    } record_result_t;

    // Every input has a known value from time zero.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [OFS_W-1:0]     capacity_bytes = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode = MODE_NOP;
    logic [OFS_W-1:0]     record_size = '0;
    logic [TAG_W-1:0]     record_tag = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [OFS_W-1:0]     record_offset;
    logic [OFS_W-1:0]     record_length;
    logic [TAG_W-1:0]     record_kind;
    logic [CNT_OUT_W-1:0] evicted_count;
    logic [CNT_OUT_W-1:0] records_held;

    ring_record_allocator_evicting DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_bytes (capacity_bytes),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .record_size    (record_size),
        .record_tag     (record_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .record_offset  (record_offset),
        .record_length  (record_length),
        .record_kind    (record_kind),
        .evicted_count  (evicted_count),
        .records_held   (records_held)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring predictor: a private copy of the allocator state, reset values
    // as after rst_n. Capacity follows every accepted config write.
    // ------------------------------------------------------------------
    logic [OFS_W-1:0]     ring_cap    = CAP_RESET;
    logic [OFS_W-1:0]     ring_head   = '0;
    logic [OFS_W-1:0]     ring_tail   = '0;
    logic [5:0]           ring_oldest = '0;
    logic [CNT_OUT_W-1:0] ring_count  = '0;
    logic [OFS_W-1:0]     ring_start [MAX_RECS];
    logic [OFS_W-1:0]     ring_len   [MAX_RECS];
    logic [TAG_W-1:0]     ring_kind  [MAX_RECS];

    record_result_t pending_results [$];
    int             mismatches  = 0;
    int             words_seen  = 0;
    bit             no_idle     = 1'b0;  // stretch with no gaps on either side
    int             hold_request = 0;    // long receiver hold-off, picked up by the sink

    function automatic int unsigned effective_capacity();
        return (ring_cap < BUF_BYTES) ? ring_cap : BUF_BYTES;
    endfunction

    // Room test: up to the capacity while head is at or past the tail,
    // up to the tail once head has wrapped below it.
    function automatic bit room_for(input logic [OFS_W-1:0] sz);
        int unsigned h;
        int unsigned t;
        h = ring_head;
        t = ring_tail;
        if (h >= t)
            return (h + sz) <= effective_capacity();
        return (h + sz) <= t;
    endfunction

    // Applies one command word to the predictor and returns its result.
    function automatic record_result_t compute_record_result(input mode_t op,
                                                             input logic [OFS_W-1:0] sz,
                                                             input logic [TAG_W-1:0] tg);
        record_result_t r;
        int unsigned    i;
        int unsigned    ev;
        int unsigned    cnt;
        int unsigned    slot;
        r   = '0;
        cnt = ring_count;
        case (op)
            MODE_PUSH:
            begin
                if (sz > effective_capacity())
                begin
                    // oversize: state untouched, request echoed back
                    r.st     = ST_OVERSIZE;
                    r.offset = ring_head;
                    r.length = sz;
                    r.kind   = tg;
                    r.held   = ring_count;
                end
                else
                begin
                    ev = 0;
                    if (cnt >= MAX_RECS || !room_for(sz))
                    begin
                        if (ring_head > ring_tail)
                            ring_head = '0;
                        // walk oldest records; tail lands on the end of each
                        for (i = 0; i < cnt; i++)
                        begin
                            slot      = (ring_oldest + i) % MAX_RECS;
                            ring_tail = ring_start[slot] + ring_len[slot];
                            if (room_for(sz))
                                break;
                        end
                        // no room even with all gone: record goes at head anyway
                        ev          = (i + 1 < cnt) ? i + 1 : cnt;
                        ring_oldest = (ring_oldest + ev) % MAX_RECS;
                        cnt         = cnt - ev;
                    end
                    slot             = (ring_oldest + cnt) % MAX_RECS;
                    ring_start[slot] = ring_head;
                    ring_len[slot]   = sz;
                    ring_kind[slot]  = tg;
                    cnt              = cnt + 1;
                    ring_count       = cnt;
                    r.st      = ST_OK;
                    r.offset  = ring_head;
                    r.length  = sz;
                    r.kind    = tg;
                    r.evicted = ev;
                    r.held    = ring_count;
                    ring_head = ring_head + sz;  // 15-bit wrap
                end
            end
            MODE_POP:
            begin
                if (cnt == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    slot       = (ring_oldest + cnt - 1) % MAX_RECS;
                    ring_count = cnt - 1;
                    ring_head  = ring_start[slot];
                    r.st     = ST_OK;
                    r.offset = ring_start[slot];
                    r.length = ring_len[slot];
                    r.kind   = ring_kind[slot];
                    r.held   = ring_count;
                end
            end
            MODE_CLEAR:
            begin
                ring_head   = '0;
                ring_tail   = '0;
                ring_oldest = '0;
                ring_count  = '0;
            end
            default:
                r.held = ring_count;
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int unsigned pick_size();
        int unsigned eff;
        int unsigned r;
        int unsigned over;
        eff = effective_capacity();
        r   = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(0, SIZE_MAX);
        if (r < 10)
        begin
            over = eff + $urandom_range(1, 64);
            return (over > SIZE_MAX) ? SIZE_MAX : over;
        end
        if (r < 15)
            return eff;
        if (r < 20)
            return 0;
        if (r < 60)
            return $urandom_range(0, eff / 8);
        return $urandom_range(0, eff / 2);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH word %0d %s: got %0d, want %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Command side. valid rises after the gap and holds with a stable
    // payload until accepted; the predictor runs at the accepting edge.
    // If the next word follows with no gap, valid simply stays high.
    // ------------------------------------------------------------------
    task automatic send_command(input mode_t op, input int unsigned sz, input int unsigned tg);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        record_size <= sz[OFS_W-1:0];
        record_tag  <= tg[TAG_W-1:0];
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(compute_record_result(op, sz[OFS_W-1:0], tg[TAG_W-1:0]));
    endtask

    task automatic send_random_command();
        int unsigned r;
        mode_t       op;
        r = $urandom_range(0, 99);
        if (r < 64)
            op = MODE_PUSH;
        else if (r < 86)
            op = MODE_POP;
        else if (r < 90)
            op = MODE_CLEAR;
        else
            op = MODE_NOP;
        // size and tag stay random on non-push words too; they must be ignored
        send_command(op, pick_size(), $urandom_range(0, 255));
    endtask

    // Stop offering and wait for every outstanding result. Each word yields
    // exactly one result, so an empty queue means the block is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        cfg_valid      <= 1'b1;
        capacity_bytes <= value[OFS_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_cap  = value[OFS_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted word against the oldest
    // prediction, then choose out_ready for the next edge.
    // ------------------------------------------------------------------
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin : result_sink
        record_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word, offset", record_offset, -1);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (record_offset !== want.offset)
                    report_mismatch("record_offset", record_offset, want.offset);
                if (record_length !== want.length)
                    report_mismatch("record_length", record_length, want.length);
                if (record_kind !== want.kind)
                    report_mismatch("record_kind", record_kind, want.kind);
                if (evicted_count !== want.evicted)
                    report_mismatch("evicted_count", evicted_count, want.evicted);
                if (records_held !== want.held)
                    report_mismatch("records_held", records_held, want.held);
            end
        end
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset capacity: pop on empty, zero and exact-fit pushes, oversize
    // (just over and all ones), eviction of the oldest, pops, clear, no-op.
    task automatic test_basic_commands();
        send_command(MODE_POP,   0, 0);
        send_command(MODE_PUSH,  0, 8'h00);
        send_command(MODE_PUSH,  10240, 8'hFF);
        send_command(MODE_PUSH,  10241, 8'h3C);
        send_command(MODE_PUSH,  SIZE_MAX, 8'hA5);
        send_command(MODE_PUSH,  1, 8'h01);
        send_command(MODE_NOP,   SIZE_MAX, 8'hFF);
        send_command(MODE_POP,   0, 0);
        send_command(MODE_CLEAR, 77, 8'h5A);
        send_command(MODE_POP,   0, 0);
    endtask

    // Small ring: head wraps to 0, then a push that does not fit even with
    // every record evicted is placed at the head anyway.
    task automatic test_evict_all_and_wrap();
        drain_results();
        write_capacity(100);
        send_command(MODE_PUSH, 30, 8'h11);
        send_command(MODE_PUSH, 50, 8'h22);
        send_command(MODE_PUSH, 90, 8'h33);
        send_command(MODE_PUSH, 20, 8'h44);
        send_command(MODE_PUSH, 101, 8'h55);
        send_command(MODE_POP,  0, 0);
        send_command(MODE_POP,  0, 0);
    endtask

    // Full-size ring driven so the head runs past 16383 and wraps at 15 bits.
    task automatic test_offset_overflow();
        drain_results();
        write_capacity(BUF_BYTES);
        send_command(MODE_CLEAR, 0, 0);
        send_command(MODE_PUSH,  16000, 8'h80);
        send_command(MODE_PUSH,  16000, 8'h81);
        send_command(MODE_PUSH,  BUF_BYTES, 8'h82);
        send_command(MODE_PUSH,  BUF_BYTES, 8'h83);
        send_command(MODE_PUSH,  BUF_BYTES, 8'h84);
        send_command(MODE_PUSH,  0, 8'h85);
        send_command(MODE_POP,   0, 0);
    endtask

    // A one-byte capacity, then a register value above the buffer size,
    // which must clamp to BUFFER_BYTES.
    task automatic test_capacity_extremes();
        drain_results();
        write_capacity(1);
        send_command(MODE_PUSH, 1, 8'hC1);
        send_command(MODE_PUSH, 1, 8'hC2);
        send_command(MODE_PUSH, 2, 8'hC3);
        drain_results();
        write_capacity(SIZE_MAX);
        send_command(MODE_PUSH, BUF_BYTES, 8'hD0);
        send_command(MODE_PUSH, BUF_BYTES + 1, 8'hD1);
    endtask

    // Many tiny records back to back so the list hits MAX_RECORDS and
    // evicts on count; a final full-size push then evicts all of them.
    task automatic test_list_full();
        int i;
        no_idle = 1'b1;
        send_command(MODE_CLEAR, 0, 0);
        for (i = 0; i < 140; i++)
            send_command(MODE_PUSH, $urandom_range(0, 40), $urandom_range(0, 255));
        send_command(MODE_PUSH, BUF_BYTES, 8'hEE);
        for (i = 0; i < 3; i++)
            send_command(MODE_POP, 0, 0);
        no_idle = 1'b0;
    endtask

    // Receiver holds off for a long stretch while words keep coming, so
    // the output register fills and in_ready drops.
    task automatic test_output_stall();
        int i;
        drain_results();
        hold_request = 300;
        no_idle      = 1'b1;
        for (i = 0; i < 60; i++)
            send_random_command();
        no_idle = 1'b0;
    endtask

    // Random mix under a series of capacity settings.
    task automatic test_random_mix();
        int unsigned caps [7];
        int          p;
        int          i;
        caps[0] = CAP_RESET;
        caps[1] = 200;
        caps[2] = BUF_BYTES;
        caps[3] = 64;
        caps[4] = $urandom_range(1, BUF_BYTES);
        caps[5] = $urandom_range(1, SIZE_MAX);
        caps[6] = SIZE_MAX;
        for (p = 0; p < 7; p++)
        begin
            drain_results();
            write_capacity(caps[p]);
            for (i = 0; i < 174; i++)
                send_random_command();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_commands();
        test_evict_all_and_wrap();
        test_offset_overflow();
        test_capacity_extremes();
        test_list_full();
        test_output_stall();
        test_random_mix();
        drain_results();
        // worst push walks every record; give any stray word time to show
        repeat (2 * MAX_RECS + 8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (mismatches == 0)
            $display("tb_ring_record_allocator_evicting OK");
        else
            $display("tb_ring_record_allocator_evicting NOT OK");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb_ring_record_allocator_evicting NOT OK");
        $finish;
    end

endmodule

### ring_record_allocator_evicting.f
+incdir+rtl
rtl/rrae_pkg.sv
rtl/rrae_ram.sv
rtl/rrae_ctrl.sv
rtl/rrae_dp.sv
rtl/ring_record_allocator_evicting.sv
dv/tb_ring_record_allocator_evicting.sv
